// ===== rtl/rkg_pkg.sv =====
// Shared widths, register indexes and key status codes for the small RSA block.
// No dependencies; imported by rsa_keygen_and_round_trip.
package rkg_pkg;

	// Fixed field widths
	localparam int WORD_W     = 32;
	localparam int SEED_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int STATUS_W   = 2;
	// Signed width of the Bezout coefficient and its partial products
	localparam int T_W        = WORD_W + 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [STATUS_W-1:0]  key_status_t;

	// Configuration register indexes
	localparam cfg_idx_t REG_FIRST_SEED  = 2'd0;
	localparam cfg_idx_t REG_SECOND_SEED = 2'd1;
	localparam cfg_idx_t REG_PUBLIC_EXP  = 2'd2;

	// Key status codes
	localparam key_status_t ST_OK    = 2'd0;
	localparam key_status_t ST_NOINV = 2'd1;
	localparam key_status_t ST_OVF   = 2'd2;

endpackage

// ===== rtl/rsa_keygen_and_round_trip.sv =====
// Small RSA block: prime search, private exponent derivation and a round trip
// of encryption and decryption, all on bit-serial datapaths.
// Depends on rkg_pkg.

// On the first transaction after reset or after a write to any of the three
// configuration registers the block derives a key: it searches up from each
// seed (low bit forced high) for a prime by trial division, one remainder bit
// per cycle, multiplies the primes one bit per cycle, and runs the extended
// Euclidean algorithm with a bit-serial divider. The key is then cached.
// Each message costs a serial reduction of the message modulo n plus two
// modular exponentiations of 32 exponent bits; each exponent bit takes a
// serial modular squaring and, for a set bit, a serial multiply. Without an
// inverse the decryption is skipped; with an overflowed key encryption and
// decryption are both skipped and both results are zero. Key derivation
// adds the trial divisions, one per odd divisor tried, and the Euclid steps.
// One message is handled at a time; a result waits in the output register
// while the next message may already be accepted.
module rsa_keygen_and_round_trip #(
	parameter int PRIME_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rkg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rkg_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rkg_pkg::WORD_W-1:0]          message,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rkg_pkg::WORD_W-1:0]          cipher,
	output logic [rkg_pkg::WORD_W-1:0]          recovered,
	output logic [rkg_pkg::WORD_W-1:0]          modulus,
	output logic [rkg_pkg::WORD_W-1:0]          private_exp,
	output logic [rkg_pkg::STATUS_W-1:0]        key_status
);
	import rkg_pkg::*;

	localparam int PW = PRIME_WIDTH;
	localparam int XW = ((PW > SEED_W) ? PW : SEED_W) + 1;
	localparam int DW = (XW > WORD_W) ? XW : WORD_W;
	localparam int CW = $clog2(DW + 1);
	localparam logic [XW-1:0] LIMIT = XW'((65'd1 << PW) - 65'd1);

	typedef enum logic [3:0] {
		S_IDLE, S_PINIT, S_PCHK, S_PTEST, S_PDIV, S_PMUL, S_EEA_CHK, S_EEA_DIV,
		S_START, S_BASE, S_EBIT, S_MM, S_DONE
	} state_t;

	state_t state_q;

	// Configuration and cached key
	logic [SEED_W-1:0]  seed0_q, seed1_q;
	logic [WORD_W-1:0]  pexp_q;
	logic               key_ready_q;
	logic [PW-1:0]      p_q, qsh_q;
	logic [WORD_W-1:0]  n_q, phi_q, secret_q;
	key_status_t        status_q;

	// Prime search
	logic               sel_q;
	logic [XW-1:0]      x_q, f_q;
	logic [XW:0]        sq_q;

	// Shared restoring divider
	logic [DW-1:0]      dsh_q, rem_q, dv_q;
	logic [CW-1:0]      cnt_q;
	logic [DW:0]        rem2, rem_nx;
	logic               dge;

	// Serial product of the primes
	logic [2*PW-1:0]    pm_q, pm_nx;
	logic [2*PW+31:0]   pm_wide;
	logic [WORD_W-1:0]  phi_nx;

	// Extended Euclid
	logic [WORD_W-1:0]          r0_q, r1_q;
	logic signed [T_W-1:0]      t0_q, t1_q, prod_q, prod_nx, tfix;

	// Exponentiation and serial modular multiply
	logic [WORD_W-1:0]  msg_q, base_q, acc_q, esh_q, ma_q, mb_q, mr_q, mr_nx;
	logic [WORD_W-1:0]  c_q, rec_q;
	logic [5:0]         ecnt_q;
	logic               pass_q, mulph_q;
	logic [WORD_W+1:0]  mt, mt1, mt2, n34;

	assign in_ready = (state_q == S_IDLE);

	// Divider step: bring down one dividend bit, subtract when it fits
	always_comb begin
		rem2    = {rem_q, dsh_q[DW-1]};
		dge     = (rem2 >= {1'b0, dv_q});
		rem_nx  = dge ? (rem2 - {1'b0, dv_q}) : rem2;
		prod_nx = (prod_q <<< 1) + (dge ? t1_q : T_W'(0));
	end

	// Multiplier step for the prime product and the totient
	always_comb begin
		pm_nx   = (pm_q << 1) + (qsh_q[PW-1] ? (2*PW)'(p_q) : (2*PW)'(0));
		pm_wide = {32'b0, pm_nx};
		phi_nx  = pm_wide[WORD_W-1:0] - WORD_W'(p_q) - WORD_W'(x_q) + WORD_W'(1);
	end

	// Interleaved modular multiply step: double, add, reduce below n
	always_comb begin
		n34 = {2'b00, n_q};
		mt  = ({2'b00, mr_q} << 1) + (ma_q[WORD_W-1] ? {2'b00, mb_q} : '0);
		mt1 = mt - n34;
		mt2 = mt - (n34 << 1);
		if (mt >= (n34 << 1)) begin
			mr_nx = mt2[WORD_W-1:0];
		end else if (mt >= n34) begin
			mr_nx = mt1[WORD_W-1:0];
		end else begin
			mr_nx = mt[WORD_W-1:0];
		end
	end

	// Bring a negative coefficient into range
	assign tfix = (t0_q < 0) ? (t0_q + signed'({3'b000, phi_q})) : t0_q;

	// Sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seed0_q     <= SEED_W'(3);
			seed1_q     <= SEED_W'(5);
			pexp_q      <= WORD_W'(3);
			key_ready_q <= 1'b0;
			status_q    <= ST_OK;
			secret_q    <= '0;
			out_valid   <= 1'b0;
		end else begin
			// writes to the configuration registers drop the cached key
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FIRST_SEED: begin
						seed0_q     <= cfg_data[SEED_W-1:0];
						key_ready_q <= 1'b0;
					end
					REG_SECOND_SEED: begin
						seed1_q     <= cfg_data[SEED_W-1:0];
						key_ready_q <= 1'b0;
					end
					REG_PUBLIC_EXP: begin
						pexp_q      <= cfg_data;
						key_ready_q <= 1'b0;
					end
					default: ;
				endcase
			end

			// drop the result once taken, unless a new one replaces it
			if (out_valid && out_ready && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						msg_q   <= message;
						sel_q   <= 1'b0;
						state_q <= key_ready_q ? S_START : S_PINIT;
					end
				end
				S_PINIT: begin
					x_q     <= XW'(sel_q ? seed1_q : seed0_q) | XW'(1);
					state_q <= S_PCHK;
				end
				S_PCHK: begin
					if (x_q > LIMIT) begin
						n_q         <= '0;
						secret_q    <= '0;
						status_q    <= ST_OVF;
						key_ready_q <= 1'b1;
						state_q     <= S_START;
					end else if (x_q == XW'(1)) begin
						x_q <= x_q + XW'(2);
					end else begin
						f_q     <= XW'(3);
						sq_q    <= (XW+1)'(9);
						state_q <= S_PTEST;
					end
				end
				S_PTEST: begin
					if (sq_q > {1'b0, x_q}) begin
						// candidate is prime
						if (!sel_q) begin
							p_q     <= PW'(x_q);
							sel_q   <= 1'b1;
							state_q <= S_PINIT;
						end else begin
							qsh_q   <= PW'(x_q);
							pm_q    <= '0;
							cnt_q   <= CW'(PW);
							state_q <= S_PMUL;
						end
					end else begin
						dsh_q   <= DW'(x_q);
						rem_q   <= '0;
						dv_q    <= DW'(f_q);
						cnt_q   <= CW'(DW);
						state_q <= S_PDIV;
					end
				end
				S_PDIV: begin
					dsh_q <= dsh_q << 1;
					rem_q <= rem_nx[DW-1:0];
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						if (rem_nx == '0) begin
							x_q     <= x_q + XW'(2);
							state_q <= S_PCHK;
						end else begin
							f_q     <= f_q + XW'(2);
							sq_q    <= sq_q + (XW+1)'({f_q, 2'b00}) + (XW+1)'(4);
							state_q <= S_PTEST;
						end
					end
				end
				S_PMUL: begin
					pm_q  <= pm_nx;
					qsh_q <= qsh_q << 1;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						if (|pm_wide[2*PW+31:WORD_W]) begin
							n_q         <= '0;
							secret_q    <= '0;
							status_q    <= ST_OVF;
							key_ready_q <= 1'b1;
							state_q     <= S_START;
						end else begin
							n_q     <= pm_wide[WORD_W-1:0];
							phi_q   <= phi_nx;
							r0_q    <= phi_nx;
							r1_q    <= pexp_q;
							t0_q    <= '0;
							t1_q    <= T_W'(1);
							state_q <= S_EEA_CHK;
						end
					end
				end
				S_EEA_CHK: begin
					if (r1_q == '0) begin
						if (r0_q == WORD_W'(1)) begin
							secret_q <= tfix[WORD_W-1:0];
							status_q <= (tfix[WORD_W-1:0] == '0) ? ST_NOINV : ST_OK;
						end else begin
							secret_q <= '0;
							status_q <= ST_NOINV;
						end
						key_ready_q <= 1'b1;
						state_q     <= S_START;
					end else begin
						dsh_q   <= DW'(r0_q);
						rem_q   <= '0;
						dv_q    <= DW'(r1_q);
						prod_q  <= '0;
						cnt_q   <= CW'(DW);
						state_q <= S_EEA_DIV;
					end
				end
				S_EEA_DIV: begin
					dsh_q  <= dsh_q << 1;
					rem_q  <= rem_nx[DW-1:0];
					prod_q <= prod_nx;
					cnt_q  <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						r0_q    <= r1_q;
						r1_q    <= rem_nx[WORD_W-1:0];
						t0_q    <= t1_q;
						t1_q    <= t0_q - prod_nx;
						state_q <= S_EEA_CHK;
					end
				end
				S_START: begin
					if (status_q == ST_OVF) begin
						c_q     <= '0;
						rec_q   <= '0;
						state_q <= S_DONE;
					end else begin
						dsh_q   <= DW'(msg_q);
						rem_q   <= '0;
						dv_q    <= DW'(n_q);
						cnt_q   <= CW'(DW);
						state_q <= S_BASE;
					end
				end
				S_BASE: begin
					dsh_q <= dsh_q << 1;
					rem_q <= rem_nx[DW-1:0];
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						base_q  <= rem_nx[WORD_W-1:0];
						acc_q   <= WORD_W'(1);
						esh_q   <= pexp_q;
						ecnt_q  <= 6'(WORD_W);
						pass_q  <= 1'b0;
						state_q <= S_EBIT;
					end
				end
				S_EBIT: begin
					if (ecnt_q == '0) begin
						if (!pass_q) begin
							c_q <= acc_q;
							if (status_q == ST_OK) begin
								base_q  <= acc_q;
								acc_q   <= WORD_W'(1);
								esh_q   <= secret_q;
								ecnt_q  <= 6'(WORD_W);
								pass_q  <= 1'b1;
							end else begin
								rec_q   <= '0;
								state_q <= S_DONE;
							end
						end else begin
							rec_q   <= acc_q;
							state_q <= S_DONE;
						end
					end else begin
						ma_q    <= acc_q;
						mb_q    <= acc_q;
						mr_q    <= '0;
						cnt_q   <= CW'(WORD_W);
						mulph_q <= 1'b0;
						state_q <= S_MM;
					end
				end
				S_MM: begin
					if (cnt_q == CW'(1) && !mulph_q && esh_q[WORD_W-1]) begin
						// square done, multiply by the base
						ma_q    <= mr_nx;
						mb_q    <= base_q;
						mr_q    <= '0;
						cnt_q   <= CW'(WORD_W);
						mulph_q <= 1'b1;
					end else begin
						ma_q  <= ma_q << 1;
						mr_q  <= mr_nx;
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							acc_q   <= mr_nx;
							esh_q   <= esh_q << 1;
							ecnt_q  <= ecnt_q - 6'd1;
							state_q <= S_EBIT;
						end
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid   <= 1'b1;
						cipher      <= c_q;
						recovered   <= rec_q;
						modulus     <= n_q;
						private_exp <= secret_q;
						key_status  <= status_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
